// File: sv/shortest_match_dictionary_substitution_defines.svh
// Assertion helpers shared by the checker.
`ifndef SHORTEST_MATCH_DICTIONARY_SUBSTITUTION_DEFINES_SVH
`define SHORTEST_MATCH_DICTIONARY_SUBSTITUTION_DEFINES_SVH

// same-cycle implication
`define SMDS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smds check failed");

// next-cycle implication
`define SMDS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smds check failed");

`endif

// File: sv/smds_pkg.sv
package smds_pkg;

  localparam int ENTRIES   = 64;
  localparam int KEY_BYTES = 8;
  localparam int REP_BYTES = 8;

  localparam int IDX_W  = 6;
  localparam int POS_W  = 3;
  localparam int LEN_W  = 4;
  localparam int CNT_W  = 7;
  localparam int KEY_W  = KEY_BYTES * 8;
  // key word: keyword bytes, then keyword length, then replacement length
  localparam int KWORD_W = KEY_W + 2 * LEN_W;
  localparam int KL_LSB  = KEY_W;
  localparam int RL_LSB  = KEY_W + LEN_W;

  localparam logic [CNT_W-1:0] ENTRY_MAX = CNT_W'(ENTRIES);
  localparam logic [LEN_W-1:0] KEY_MAX   = LEN_W'(KEY_BYTES);
  localparam logic [LEN_W-1:0] REP_MAX   = LEN_W'(REP_BYTES);
  localparam logic [LEN_W-1:0] LEN_NONE  = LEN_W'(KEY_BYTES + 1);

  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-1:0] ADDR_ENTRY_COUNT = 3'd0;

  typedef enum logic [1:0] {
    REQ_KEY  = 2'd0,
    REQ_REPL = 2'd1,
    REQ_LEN  = 2'd2,
    REQ_TEXT = 2'd3
  } req_t;

  typedef struct packed {
    logic             push;
    logic [7:0]       data;
    logic             shift;
    logic [LEN_W-1:0] adv;
  } win_cmd_t;

endpackage

// File: sv/smds_ram.sv
module smds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/smds_window.sv
module smds_window (
  input  logic                          clk,
  input  logic                          rst,
  input  smds_pkg::win_cmd_t            cmd,
  output logic [7:0]                    win [smds_pkg::KEY_BYTES],
  output logic [smds_pkg::LEN_W-1:0]    fill
);

  logic [smds_pkg::LEN_W:0] src [smds_pkg::KEY_BYTES];

  always_comb begin
    for (int i = 0; i < smds_pkg::KEY_BYTES; i++) begin
      src[i] = (smds_pkg::LEN_W+1)'(i) + {1'b0, cmd.adv};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.push) begin
      fill <= fill + 1'b1;
    end else if (cmd.shift) begin
      fill <= fill - cmd.adv;
    end
  end

  // head shift by match len or 1; tail bytes left stale
  always_ff @(posedge clk) begin
    for (int i = 0; i < smds_pkg::KEY_BYTES; i++) begin
      if (cmd.push && fill == smds_pkg::LEN_W'(i)) begin
        win[i] <= cmd.data;
      end else if (cmd.shift && src[i] < (smds_pkg::LEN_W+1)'(smds_pkg::KEY_BYTES)) begin
        win[i] <= win[src[i][smds_pkg::LEN_W-2:0]];
      end
    end
  end

endmodule

// File: sv/shortest_match_dictionary_substitution.sv
// Replacement byte loads write on acceptance; keyword byte and length loads merge in
// S_MERGE. A text beat that fills the window or ends the text starts, per head decision,
// a key-table scan of min(entry_count,64) entries (one entry word per cycle), then
// S_RREAD (repl RAM read) and S_RPUT per replacement byte or S_PASS for a pass-through,
// then S_SHIFT. End of text flushes up to 8 decisions. One beat is worked on at a time.
// Reset (rst, sync, high) clears control, fill, entry_count and length valid bits.
module shortest_match_dictionary_substitution (
  input  logic        clk,
  input  logic        rst,
  // config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input beats
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [5:0]  entry_index,
  input  logic [2:0]  char_pos,
  input  logic [7:0]  char_value,
  input  logic [3:0]  key_len,
  input  logic [3:0]  repl_len,
  input  logic        end_of_text,
  // result beats
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        last_of_run,
  output logic        text_done
);

  localparam int LW = smds_pkg::LEN_W;
  localparam int IW = smds_pkg::IDX_W;
  localparam int PW = smds_pkg::POS_W;
  localparam int CW = smds_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_MERGE, S_SCAN, S_RREAD, S_RPUT, S_PASS, S_SHIFT
  } state_t;

  state_t state;

  // config register
  logic [CW-1:0] entry_count;
  logic [CW-1:0] cnt;

  // latched load beat
  smds_pkg::req_t ld_type;
  logic [IW-1:0]  ld_idx;
  logic [PW-1:0]  ld_pos;
  logic [7:0]     ld_char;
  logic [LW-1:0]  ld_kl;
  logic [LW-1:0]  ld_rl;
  logic           eot_q;

  // scan and decision
  logic [CW-1:0]  scan_ctr;
  logic           ev_vld;
  logic [IW-1:0]  ev_idx;
  logic           found;
  logic [IW-1:0]  best_idx;
  logic [LW-1:0]  best_len;
  logic [LW-1:0]  best_rl;
  logic [PW-1:0]  rep_ctr;
  logic [LW-1:0]  adv;
  logic           len_vld [smds_pkg::ENTRIES];

  // memories
  logic                          key_we;
  logic [smds_pkg::KWORD_W-1:0]  key_wdata;
  logic [smds_pkg::KWORD_W-1:0]  key_rdata;
  logic [IW-1:0]                 key_raddr;
  logic                          rep_we;
  logic [7:0]                    rep_rdata;

  // window
  smds_pkg::win_cmd_t wcmd;
  logic [7:0]         win [smds_pkg::KEY_BYTES];
  logic [LW-1:0]      fill;

  logic          in_acc;
  logic          out_free;
  logic [LW-1:0] ev_kl;
  logic          ev_hit;
  logic          more;
  logic [LW-1:0] kl_sat;
  logic [LW-1:0] rl_sat;

  assign pready   = 1'b1;
  assign prdata   = (paddr == smds_pkg::ADDR_ENTRY_COUNT) ? {25'd0, entry_count} : 32'd0;
  assign cnt      = (entry_count > smds_pkg::ENTRY_MAX) ? smds_pkg::ENTRY_MAX : entry_count;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // after this decision: another head still to decide at end of text
  assign more = eot_q && (fill != adv);

  assign kl_sat = (key_len > smds_pkg::KEY_MAX) ? smds_pkg::KEY_MAX : key_len;
  assign rl_sat = (repl_len > smds_pkg::REP_MAX) ? smds_pkg::REP_MAX :
                  (repl_len == '0) ? LW'(1) : repl_len;

  // entry under evaluation; lengths of a never-set entry read as disabled
  always_comb begin
    ev_kl  = len_vld[ev_idx] ? key_rdata[smds_pkg::KL_LSB +: LW] : '0;
    ev_hit = (ev_kl != '0) && (ev_kl <= fill) && (ev_kl < best_len);
    for (int j = 0; j < smds_pkg::KEY_BYTES; j++) begin
      if (LW'(j) < ev_kl && key_rdata[j*8 +: 8] != win[j]) begin
        ev_hit = 1'b0;
      end
    end
  end

  // key table port: scan address while scanning, else follow the input beat
  assign key_raddr = (state == S_SCAN) ? scan_ctr[IW-1:0] : entry_index;
  assign key_we    = (state == S_MERGE);

  // read-modify-write merge of one keyword byte or the length pair
  always_comb begin
    key_wdata = key_rdata;
    if (ld_type == smds_pkg::REQ_KEY) begin
      key_wdata[{ld_pos, 3'b000} +: 8] = ld_char;
    end else begin
      key_wdata[smds_pkg::KL_LSB +: LW] = ld_kl;
      key_wdata[smds_pkg::RL_LSB +: LW] = ld_rl;
    end
  end

  assign rep_we = in_acc && (smds_pkg::req_t'(req_type) == smds_pkg::REQ_REPL);

  always_comb begin
    wcmd       = '0;
    wcmd.data  = char_value;
    wcmd.adv   = adv;
    wcmd.push  = in_acc && (smds_pkg::req_t'(req_type) == smds_pkg::REQ_TEXT);
    wcmd.shift = (state == S_SHIFT);
  end

  smds_ram #(
    .WIDTH (smds_pkg::KWORD_W),
    .DEPTH (smds_pkg::ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (ld_idx),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  smds_ram #(
    .WIDTH (8),
    .DEPTH (smds_pkg::ENTRIES * smds_pkg::REP_BYTES)
  ) u_rep_ram (
    .clk   (clk),
    .we    (rep_we),
    .waddr ({entry_index, char_pos}),
    .wdata (char_value),
    .raddr ({best_idx, rep_ctr}),
    .rdata (rep_rdata)
  );

  smds_window u_win (
    .clk  (clk),
    .rst  (rst),
    .cmd  (wcmd),
    .win  (win),
    .fill (fill)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      out_valid   <= 1'b0;
      eot_q       <= 1'b0;
      ev_vld      <= 1'b0;
      found       <= 1'b0;
      for (int i = 0; i < smds_pkg::ENTRIES; i++) begin
        len_vld[i] <= 1'b0;
      end
    end else begin
      if (psel && penable && pwrite && pready && paddr == smds_pkg::ADDR_ENTRY_COUNT) begin
        entry_count <= pwdata[CW-1:0];
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            ld_type <= smds_pkg::req_t'(req_type);
            ld_idx  <= entry_index;
            ld_pos  <= char_pos;
            ld_char <= char_value;
            ld_kl   <= kl_sat;
            ld_rl   <= rl_sat;
            case (smds_pkg::req_t'(req_type))
              smds_pkg::REQ_KEY, smds_pkg::REQ_LEN: begin
                state <= S_MERGE;
              end
              smds_pkg::REQ_TEXT: begin
                eot_q <= end_of_text;
                if (end_of_text || fill == LW'(smds_pkg::KEY_BYTES - 1)) begin
                  state    <= S_SCAN;
                  scan_ctr <= '0;
                  ev_vld   <= 1'b0;
                  found    <= 1'b0;
                  best_len <= smds_pkg::LEN_NONE;
                end
              end
              default: ;
            endcase
          end
        end
        S_MERGE: begin
          if (ld_type == smds_pkg::REQ_LEN) begin
            len_vld[ld_idx] <= 1'b1;
          end
          state <= S_IDLE;
        end
        S_SCAN: begin
          if (ev_vld && ev_hit) begin
            found    <= 1'b1;
            best_idx <= ev_idx;
            best_len <= ev_kl;
            best_rl  <= key_rdata[smds_pkg::RL_LSB +: LW];
          end
          if (scan_ctr < cnt) begin
            ev_vld   <= 1'b1;
            ev_idx   <= scan_ctr[IW-1:0];
            scan_ctr <= scan_ctr + 1'b1;
          end else begin
            ev_vld <= 1'b0;
            if (!ev_vld) begin
              rep_ctr <= '0;
              if (found) begin
                adv   <= best_len;
                state <= S_RREAD;
              end else begin
                adv   <= LW'(1);
                state <= S_PASS;
              end
            end
          end
        end
        S_RREAD: begin
          state <= S_RPUT;
        end
        S_RPUT: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_char    <= rep_rdata;
            last_of_run <= ({1'b0, rep_ctr} == best_rl - 1'b1) && !more;
            text_done   <= ({1'b0, rep_ctr} == best_rl - 1'b1) && !more && eot_q;
            if ({1'b0, rep_ctr} == best_rl - 1'b1) begin
              state <= S_SHIFT;
            end else begin
              rep_ctr <= rep_ctr + 1'b1;
              state   <= S_RREAD;
            end
          end
        end
        S_PASS: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_char    <= win[0];
            last_of_run <= !more;
            text_done   <= !more && eot_q;
            state       <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (more) begin
            state    <= S_SCAN;
            scan_ctr <= '0;
            ev_vld   <= 1'b0;
            found    <= 1'b0;
            best_len <= smds_pkg::LEN_NONE;
          end else begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/smds_checker.sv
`include "shortest_match_dictionary_substitution_defines.svh"

module smds_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] req_type,
  input logic       end_of_text,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_char,
  input logic       last_of_run,
  input logic       text_done
);

  logic [9:0] out_beat;
  logic       in_acc;

  assign out_beat = {out_char, last_of_run, text_done};
  assign in_acc   = in_valid && !in_stall;

  // a held result beat keeps its payload
  `SMDS_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_beat))
  // end of text always closes a run
  `SMDS_ASSERT_IMP(a_done_last, clk, rst, out_valid && text_done, last_of_run)
  // keyword byte load is a read-modify-write: input side busy next cycle
  `SMDS_ASSERT_NXT(a_key_rmw, clk, rst, in_acc && req_type == smds_pkg::REQ_KEY, in_stall)
  // end of text always starts a flush
  `SMDS_ASSERT_NXT(a_eot_flush, clk, rst, in_acc && req_type == smds_pkg::REQ_TEXT && end_of_text, in_stall)

endmodule

bind shortest_match_dictionary_substitution smds_checker u_smds_checker (.*);
